FILE: design/unix_seconds_to_civil_date_top_defines.svh
// assertion macros for the unix seconds to civil date block
`ifndef UNIX_SECONDS_TO_CIVIL_DATE_TOP_DEFINES_SVH
`define UNIX_SECONDS_TO_CIVIL_DATE_TOP_DEFINES_SVH

// same-cycle implication under reset
`define UCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ucd assertion failed");

// next-cycle implication under reset
`define UCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ucd assertion failed");

`endif

FILE: design/ucd_pkg.sv
// shared constants, control structs and month table for the civil date block
package ucd_pkg;

    localparam int MAX_YEAR     = 9999;
    localparam int IN_W         = 39;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 48;
    localparam int YEAR_W       = 14;
    localparam int MONTH_W      = 4;
    localparam int DAY_W        = 5;
    localparam int WDAY_W       = 3;
    localparam int HOUR_W       = 5;
    localparam int MIN_W        = 6;
    localparam int SEC_W        = 6;
    localparam int REM_W        = 17;

    localparam longint SECS_PER_DAY  = 86400;
    localparam longint SECS_PER_HOUR = 3600;
    localparam longint SECS_PER_MIN  = 60;
    // days from 0001-01-01 to 1970-01-01
    localparam longint EPOCH_DAYS    = 719162;
    localparam longint TOTAL_DAYS    = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                                       + MAX_YEAR / 400;

    localparam logic [IN_W-1:0]        EPOCH_OFFSET = IN_W'(EPOCH_DAYS * SECS_PER_DAY);
    localparam logic signed [IN_W-1:0] SECS_LO = IN_W'(-(EPOCH_DAYS * SECS_PER_DAY));
    localparam logic signed [IN_W-1:0] SECS_HI =
        IN_W'((TOTAL_DAYS - EPOCH_DAYS) * SECS_PER_DAY - 1);

    // 0001-01-01 was a monday
    localparam logic [WDAY_W-1:0] FIRST_WDAY = 3'd1;

    typedef struct packed {
        logic load;
        logic year_step;
        logic month_step;
        logic day_step;
        logic hms_step;
        logic store;
    } ucd_cmd_t;

    typedef struct packed {
        logic oor;
        logic year_more;
        logic month_more;
        logic day_more;
        logic hms_more;
    } ucd_status_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd2:                      len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

FILE: design/unix_seconds_to_civil_date_top.sv
// sequence: an out-of-range request goes from load to store without a walk; otherwise a load,
// then a walk one year a step from year 1 (up to 9999), then by months, by days, by hours and
// minutes, and a store, which waits while a result is still held unaccepted on the output
// throughput: one request at a time, set by the one-year-per-cycle walk
// reset: rst_n is asynchronous, active low, returns the controller to idle, no result pending
`include "unix_seconds_to_civil_date_top_defines.svh"
module unix_seconds_to_civil_date_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // unix_seconds
    input  logic [ucd_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // year, month, day, weekday, hour, minute, second
    output logic [ucd_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // out_of_range
    output logic                              m_tuser
);
    import ucd_pkg::*;

    ucd_cmd_t    cmd;
    ucd_status_t status;

    ucd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ucd_datapath u_datapath (
        .clk          (clk),
        .unix_seconds (s_tdata[IN_W-1:0]),
        .cmd          (cmd),
        .status       (status),
        .result       (m_tdata),
        .result_oor   (m_tuser)
    );

    `UCD_ASSERT_IMP(a_oor_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0)
    `UCD_ASSERT_IMP(a_date_sane, clk, rst_n, m_tvalid && !m_tuser,
                    (m_tdata[17:14] >= 4'd1) && (m_tdata[17:14] <= 4'd12) &&
                    (m_tdata[22:18] != 5'd0) && (m_tdata[25:23] <= 3'd6))
    `UCD_ASSERT_NXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `UCD_ASSERT_IMP(a_single_cmd, clk, rst_n, 1'b1, $countones(cmd) <= 1)

endmodule

FILE: design/ucd_datapath.sv
// datapath: year, month and day walk on seconds, weekday and time of day
module ucd_datapath (
    input  logic                              clk,
    input  logic [ucd_pkg::IN_W-1:0]          unix_seconds,
    input  ucd_pkg::ucd_cmd_t                 cmd,
    output ucd_pkg::ucd_status_t              status,
    output logic [ucd_pkg::OUT_TDATA_W-1:0]   result,
    output logic                              result_oor
);
    import ucd_pkg::*;

    logic [IN_W-1:0]    sreg_reg, sreg_next;
    logic               oor_reg, oor_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [1:0]         mod4_reg, mod4_next;
    logic [6:0]         mod100_reg, mod100_next;
    logic [1:0]         cent4_reg, cent4_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [WDAY_W-1:0]  wd_reg, wd_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [OUT_TDATA_W-1:0] out_reg, out_next;
    logic               out_oor_reg, out_oor_next;

    logic               leap;
    logic [IN_W-1:0]    year_secs;
    logic [DAY_W-1:0]   mlen;
    logic [IN_W-1:0]    month_secs;
    logic [REM_W-1:0]   rem;
    logic [WDAY_W:0]    wd_sum;
    logic [DAY_W-1:0]   day_out;

    assign leap      = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (cent4_reg == 2'd0));
    assign year_secs = leap ? IN_W'(366 * SECS_PER_DAY) : IN_W'(365 * SECS_PER_DAY);
    assign mlen      = month_days(month_reg, leap);
    assign rem       = sreg_reg[REM_W-1:0];
    assign day_out   = day_reg + DAY_W'(1);

    always_comb
    begin
        case (mlen)
            5'd28:   month_secs = IN_W'(28 * SECS_PER_DAY);
            5'd29:   month_secs = IN_W'(29 * SECS_PER_DAY);
            5'd30:   month_secs = IN_W'(30 * SECS_PER_DAY);
            default: month_secs = IN_W'(31 * SECS_PER_DAY);
        endcase
    end

    assign status.oor        = oor_reg;
    assign status.year_more  = sreg_reg >= year_secs;
    assign status.month_more = sreg_reg >= month_secs;
    assign status.day_more   = sreg_reg >= IN_W'(SECS_PER_DAY);
    assign status.hms_more   = rem >= REM_W'(SECS_PER_MIN);

    always_comb
    begin
        sreg_next    = sreg_reg;
        oor_next     = oor_reg;
        year_next    = year_reg;
        mod4_next    = mod4_reg;
        mod100_next  = mod100_reg;
        cent4_next   = cent4_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        wd_next      = wd_reg;
        hour_next    = hour_reg;
        min_next     = min_reg;
        out_next     = out_reg;
        out_oor_next = out_oor_reg;
        wd_sum       = '0;

        if (cmd.load)
        begin
            sreg_next   = unix_seconds + EPOCH_OFFSET;
            oor_next    = ($signed(unix_seconds) < SECS_LO) ||
                          ($signed(unix_seconds) > SECS_HI);
            year_next   = YEAR_W'(1);
            mod4_next   = 2'd1;
            mod100_next = 7'd1;
            cent4_next  = 2'd0;
            month_next  = MONTH_W'(1);
            day_next    = '0;
            wd_next     = FIRST_WDAY;
            hour_next   = '0;
            min_next    = '0;
        end

        // one year a step, weekday moves one day, two after a leap year
        if (cmd.year_step)
        begin
            sreg_next   = sreg_reg - year_secs;
            year_next   = year_reg + YEAR_W'(1);
            mod4_next   = mod4_reg + 2'd1;
            mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
            cent4_next  = (mod100_reg == 7'd99) ? cent4_reg + 2'd1 : cent4_reg;
            wd_sum      = {1'b0, wd_reg} + (leap ? (WDAY_W+1)'(2) : (WDAY_W+1)'(1));
            wd_next     = (wd_sum >= (WDAY_W+1)'(7)) ? WDAY_W'(wd_sum - (WDAY_W+1)'(7))
                                                     : wd_sum[WDAY_W-1:0];
        end

        if (cmd.month_step)
        begin
            sreg_next  = sreg_reg - month_secs;
            month_next = month_reg + MONTH_W'(1);
            wd_sum     = {1'b0, wd_reg} + (WDAY_W+1)'(mlen - 5'd28);
            wd_next    = (wd_sum >= (WDAY_W+1)'(7)) ? WDAY_W'(wd_sum - (WDAY_W+1)'(7))
                                                    : wd_sum[WDAY_W-1:0];
        end

        if (cmd.day_step)
        begin
            sreg_next = sreg_reg - IN_W'(SECS_PER_DAY);
            day_next  = day_reg + DAY_W'(1);
            wd_next   = (wd_reg == WDAY_W'(6)) ? '0 : wd_reg + WDAY_W'(1);
        end

        if (cmd.hms_step)
        begin
            if (rem >= REM_W'(SECS_PER_HOUR))
            begin
                sreg_next = IN_W'(rem - REM_W'(SECS_PER_HOUR));
                hour_next = hour_reg + HOUR_W'(1);
            end
            else
            begin
                sreg_next = IN_W'(rem - REM_W'(SECS_PER_MIN));
                min_next  = min_reg + MIN_W'(1);
            end
        end

        if (cmd.store)
        begin
            out_oor_next = oor_reg;
            if (oor_reg)
                out_next = '0;
            else
                out_next = {5'd0, rem[SEC_W-1:0], min_reg, hour_reg, wd_reg,
                            day_out, month_reg, year_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        sreg_reg    <= sreg_next;
        oor_reg     <= oor_next;
        year_reg    <= year_next;
        mod4_reg    <= mod4_next;
        mod100_reg  <= mod100_next;
        cent4_reg   <= cent4_next;
        month_reg   <= month_next;
        day_reg     <= day_next;
        wd_reg      <= wd_next;
        hour_reg    <= hour_next;
        min_reg     <= min_next;
        out_reg     <= out_next;
        out_oor_reg <= out_oor_next;
    end

    assign result     = out_reg;
    assign result_oor = out_oor_reg;

endmodule

FILE: design/ucd_ctrl.sv
// controller: sequences the year, month, day and time walks and output handshake
module ucd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  ucd_pkg::ucd_status_t  status,
    output ucd_pkg::ucd_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HMS,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               valid_reg, valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg && !m_tready;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (status.oor)
                    state_next = ST_DONE;
                else if (status.year_more)
                    cmd.year_step = 1'b1;
                else
                    state_next = ST_MONTH;
            end
            ST_MONTH:
            begin
                if (status.month_more)
                    cmd.month_step = 1'b1;
                else
                    state_next = ST_DAY;
            end
            ST_DAY:
            begin
                if (status.day_more)
                    cmd.day_step = 1'b1;
                else
                    state_next = ST_HMS;
            end
            ST_HMS:
            begin
                if (status.hms_more)
                    cmd.hms_step = 1'b1;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!valid_reg || m_tready)
                begin
                    cmd.store  = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule
